### rtl/pdg_pkg.sv
// Shared constants, codes and types of the Poisson-disc grid checker.
// No dependencies; every other file imports this package.
package pdg_pkg;

  localparam int GRID_DIM_DEF   = 64;
  localparam int COORD_BITS_DEF = 24;

  localparam int RSQ_W      = 48;
  localparam int ICW_W      = 24;
  localparam int GSZ_W      = 7;
  localparam int CELL_W     = 6;
  localparam int PROD_FRAC  = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  localparam logic [GSZ_W-1:0] GRID_SIZE_RST = 7'd64;

  localparam logic CMD_CLEAR = 1'b0;
  localparam logic CMD_TEST  = 1'b1;

  localparam int EPOCH_W = 4;
  localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

  localparam int NB_W         = 4;
  localparam int NB_COUNT     = 9;
  localparam int DRAIN_W      = 2;
  localparam int DRAIN_CYCLES = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS_SQ = 2'd0,
    REG_INV_CELL  = 2'd1,
    REG_GRID_SIZE = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_MAP,
    ST_RANGE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              accepted;
    logic              in_range;
    logic [CELL_W-1:0] cell_column;
    logic [CELL_W-1:0] cell_row;
  } res_t;

  // neighbor offset codes: 0 is minus one, 1 is zero, 2 is plus one
  function automatic logic [1:0] nb_dcol(input logic [NB_W-1:0] nb);
    logic [1:0] d;
    case (nb)
      4'd0, 4'd1, 4'd2: d = 2'd0;
      4'd3, 4'd4, 4'd5: d = 2'd1;
      4'd6, 4'd7, 4'd8: d = 2'd2;
      default:          d = 2'd1;
    endcase
    return d;
  endfunction

  function automatic logic [1:0] nb_drow(input logic [NB_W-1:0] nb);
    logic [1:0] d;
    case (nb)
      4'd0, 4'd3, 4'd6: d = 2'd0;
      4'd1, 4'd4, 4'd7: d = 2'd1;
      4'd2, 4'd5, 4'd8: d = 2'd2;
      default:          d = 2'd1;
    endcase
    return d;
  endfunction

endpackage

### rtl/pdg_ifs.sv
// Valid/ready channel interfaces: candidate input, result output, register writes.
// Depends on pdg_pkg.
interface pdg_in_if
  import pdg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;

  modport source (output valid, cmd, point_x, point_y, input ready);
  modport sink   (input valid, cmd, point_x, point_y, output ready);
endinterface

interface pdg_out_if
  import pdg_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              accepted;
  logic              in_range;
  logic [CELL_W-1:0] cell_column;
  logic [CELL_W-1:0] cell_row;

  modport source (output valid, accepted, in_range, cell_column, cell_row, input ready);
  modport sink   (input valid, accepted, in_range, cell_column, cell_row, output ready);
endinterface

interface pdg_cfg_if
  import pdg_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/pdg_grid_mem.sv
// Grid store: one write port and one read port, read data registered.
// Depends on pdg_pkg for default sizes.
module pdg_grid_mem
  import pdg_pkg::*;
#(
  parameter int DEPTH  = GRID_DIM_DEF * GRID_DIM_DEF,
  parameter int DATA_W = EPOCH_W + 2 * COORD_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/pdg_cell_map.sv
// Cell mapping: coordinate times reciprocal cell width, registered, then range check.
// Depends on pdg_pkg.
module pdg_cell_map
  import pdg_pkg::*;
#(
  parameter int GRID_DIM   = GRID_DIM_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic signed [COORD_BITS-1:0]  point_x,
  input  logic signed [COORD_BITS-1:0]  point_y,
  input  logic [ICW_W-1:0]              inv_cell_width,
  input  logic [$clog2(GRID_DIM+1)-1:0] grid_used,
  output logic                          in_range,
  output logic [$clog2(GRID_DIM)-1:0]   col_idx,
  output logic [$clog2(GRID_DIM)-1:0]   row_idx
);

  localparam int PROD_W = COORD_BITS + ICW_W + 1;
  localparam int GS_W   = $clog2(GRID_DIM + 1);
  localparam int CMP_W  = (COORD_BITS > GS_W) ? COORD_BITS : GS_W;
  localparam int CIDX_W = $clog2(GRID_DIM);

  logic signed [PROD_W-1:0] prod_x_r;
  logic signed [PROD_W-1:0] prod_y_r;
  logic signed [ICW_W:0]    icw_s;
  logic [CMP_W-1:0]         cell_x;
  logic [CMP_W-1:0]         cell_y;
  logic [CMP_W-1:0]         gs_ext;

  assign icw_s = $signed({1'b0, inv_cell_width});

  always_ff @(posedge clk) begin
    prod_x_r <= PROD_W'(point_x) * PROD_W'(icw_s);
    prod_y_r <= PROD_W'(point_y) * PROD_W'(icw_s);
  end

  assign cell_x = CMP_W'(prod_x_r[PROD_FRAC +: COORD_BITS]);
  assign cell_y = CMP_W'(prod_y_r[PROD_FRAC +: COORD_BITS]);
  assign gs_ext = CMP_W'(grid_used);

  assign in_range = !prod_x_r[PROD_W-1] && !prod_y_r[PROD_W-1] &&
                    (cell_x < gs_ext) && (cell_y < gs_ext);
  assign col_idx  = cell_x[CIDX_W-1:0];
  assign row_idx  = cell_y[CIDX_W-1:0];

endmodule

### rtl/pdg_dist.sv
// Distance pipeline: absolute differences, registered squares, compare to radius.
// Depends on pdg_pkg.
module pdg_dist
  import pdg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         chk_valid,
  input  logic signed [COORD_BITS-1:0] px,
  input  logic signed [COORD_BITS-1:0] py,
  input  logic signed [COORD_BITS-1:0] qx,
  input  logic signed [COORD_BITS-1:0] qy,
  input  logic [RSQ_W-1:0]             radius_sq,
  output logic                         hit
);

  localparam int DW   = COORD_BITS + 1;
  localparam int SQW  = 2 * DW;
  localparam int SUMW = (SQW + 1 > RSQ_W) ? SQW + 1 : RSQ_W;

  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic [DW-1:0]        adx_r;
  logic [DW-1:0]        ady_r;
  logic [SQW-1:0]       sqx_r;
  logic [SQW-1:0]       sqy_r;
  logic                 va_r;
  logic                 vb_r;

  assign dx = DW'(px) - DW'(qx);
  assign dy = DW'(py) - DW'(qy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= chk_valid;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    adx_r <= dx[DW-1] ? DW'(-dx) : DW'(dx);
    ady_r <= dy[DW-1] ? DW'(-dy) : DW'(dy);
    sqx_r <= SQW'(adx_r) * SQW'(adx_r);
    sqy_r <= SQW'(ady_r) * SQW'(ady_r);
  end

  assign hit = vb_r && ((SUMW'(sqx_r) + SUMW'(sqy_r)) < SUMW'(radius_sq));

endmodule

### rtl/poisson_disc_grid_checker.sv
// Poisson-disc grid checker: maps a candidate to its grid cell, reads the up to nine
// neighboring cells one per cycle from a single grid memory, and stores an in-grid
// candidate only if no stored point is at a squared distance below the squared radius.
// A test item passes through accept, multiply, range check, nine reads on the one read
// port, a distance-pipeline drain and write-back before the next acceptance; a candidate
// outside the grid skips the reads and drain, and a clear goes straight to its result.
// Each cell carries a 4-bit clear epoch, so a clear only bumps the epoch; every fifteenth
// clear, and reset, run a pass clearing all GRID_DIM*GRID_DIM cells with the input stalled.
// Depends on pdg_pkg, pdg_ifs, pdg_grid_mem, pdg_cell_map and pdg_dist.
module poisson_disc_grid_checker
  import pdg_pkg::*;
#(
  parameter int GRID_DIM   = GRID_DIM_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  pdg_in_if.sink    in_chan,
  pdg_out_if.source out_chan,
  pdg_cfg_if.sink   cfg_chan
);

  localparam int CIDX_W = $clog2(GRID_DIM);
  localparam int NIDX_W = CIDX_W + 1;
  localparam int GS_W   = $clog2(GRID_DIM + 1);
  localparam int MIN_W  = (GS_W > GSZ_W) ? GS_W : GSZ_W;
  localparam int DEPTH  = GRID_DIM * GRID_DIM;
  localparam int AW     = $clog2(DEPTH);
  localparam int PT_W   = 2 * COORD_BITS;
  localparam int WORD_W = EPOCH_W + PT_W;

  localparam logic [AW-1:0] DIM_A   = AW'(GRID_DIM);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

  state_t state_r;
  state_t state_nxt;

  logic [RSQ_W-1:0]             rsq_r;
  logic [ICW_W-1:0]             icw_r;
  logic [GSZ_W-1:0]             grid_size_r;
  logic                         cmd_r;
  logic signed [COORD_BITS-1:0] px_r;
  logic signed [COORD_BITS-1:0] py_r;
  logic [EPOCH_W-1:0]           epoch_r;
  logic [NB_W-1:0]              nb_r;
  logic [DRAIN_W-1:0]           drain_r;
  logic [AW-1:0]                sweep_r;
  logic                         conflict_r;
  logic                         clr_pend_r;
  logic                         rd_ok_r;
  logic                         out_valid_r;
  res_t                         out_res_r;

  logic [MIN_W-1:0]  gs_wide;
  logic [GS_W-1:0]   gs;
  logic              map_in_range;
  logic [CIDX_W-1:0] col_idx;
  logic [CIDX_W-1:0] row_idx;
  logic [NIDX_W-1:0] nb_col;
  logic [NIDX_W-1:0] nb_row;
  logic              nb_ok;
  logic [AW-1:0]     cell_addr;
  logic [AW-1:0]     nb_addr;

  logic              in_fire;
  logic              out_free;
  logic              sweep_end;
  logic              mem_we;
  logic              mem_re;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [WORD_W-1:0] mem_rdata;
  logic              chk_valid;
  logic              hit;
  logic              store_ok;
  res_t              res;

  // configuration
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsq_r       <= '0;
      icw_r       <= '0;
      grid_size_r <= GRID_SIZE_RST;
    end else if (cfg_chan.valid) begin
      case (cfg_reg_t'(cfg_chan.index))
        REG_RADIUS_SQ: rsq_r       <= cfg_chan.data[RSQ_W-1:0];
        REG_INV_CELL:  icw_r       <= cfg_chan.data[ICW_W-1:0];
        REG_GRID_SIZE: grid_size_r <= cfg_chan.data[GSZ_W-1:0];
        default: ;
      endcase
    end
  end

  assign gs_wide = (MIN_W'(grid_size_r) > MIN_W'(GRID_DIM)) ? MIN_W'(GRID_DIM)
                                                            : MIN_W'(grid_size_r);
  assign gs      = gs_wide[GS_W-1:0];

  pdg_cell_map #(
    .GRID_DIM   (GRID_DIM),
    .COORD_BITS (COORD_BITS)
  ) u_map (
    .clk            (clk),
    .point_x        (px_r),
    .point_y        (py_r),
    .inv_cell_width (icw_r),
    .grid_used      (gs),
    .in_range       (map_in_range),
    .col_idx        (col_idx),
    .row_idx        (row_idx)
  );

  // neighbor walk
  assign nb_col    = NIDX_W'(col_idx) + NIDX_W'(nb_dcol(nb_r)) - NIDX_W'(1);
  assign nb_row    = NIDX_W'(row_idx) + NIDX_W'(nb_drow(nb_r)) - NIDX_W'(1);
  assign nb_ok     = (nb_col < NIDX_W'(gs)) && (nb_row < NIDX_W'(gs));
  assign nb_addr   = AW'(nb_col[CIDX_W-1:0]) * DIM_A + AW'(nb_row[CIDX_W-1:0]);
  assign cell_addr = AW'(col_idx) * DIM_A + AW'(row_idx);

  pdg_grid_mem #(
    .DEPTH  (DEPTH),
    .DATA_W (WORD_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (nb_addr),
    .rdata (mem_rdata)
  );

  assign chk_valid = rd_ok_r && (mem_rdata[WORD_W-1 -: EPOCH_W] == epoch_r);

  pdg_dist #(
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .chk_valid (chk_valid),
    .px        (px_r),
    .py        (py_r),
    .qx        (mem_rdata[PT_W-1:COORD_BITS]),
    .qy        (mem_rdata[COORD_BITS-1:0]),
    .radius_sq (rsq_r),
    .hit       (hit)
  );

  assign in_fire   = in_chan.valid && in_chan.ready;
  assign out_free  = !out_valid_r || out_chan.ready;
  assign sweep_end = (sweep_r == LAST_A);
  assign store_ok  = (cmd_r == CMD_TEST) && map_in_range && !conflict_r;

  always_comb begin
    res.accepted    = store_ok;
    res.in_range    = (cmd_r == CMD_TEST) && map_in_range;
    res.cell_column = res.in_range ? CELL_W'(col_idx) : '0;
    res.cell_row    = res.in_range ? CELL_W'(row_idx) : '0;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_SWEEP: begin
        if (sweep_end) begin
          state_nxt = clr_pend_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (in_chan.cmd == CMD_TEST) begin
            state_nxt = ST_MAP;
          end else if (epoch_r == EPOCH_LAST) begin
            state_nxt = ST_SWEEP;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_MAP:   state_nxt = ST_RANGE;
      ST_RANGE: state_nxt = map_in_range ? ST_SCAN : ST_DONE;
      ST_SCAN: begin
        if (nb_r == NB_W'(NB_COUNT - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_r == DRAIN_W'(DRAIN_CYCLES - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_chan.ready = 1'b0;
    mem_re        = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = cell_addr;
    mem_wdata     = {epoch_r, px_r, py_r};
    case (state_r)
      ST_IDLE:  in_chan.ready = 1'b1;
      ST_SCAN:  mem_re = 1'b1;
      ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_r;
        mem_wdata = {EPOCH_NONE, {PT_W{1'b0}}};
      end
      ST_DONE:  mem_we = out_free && store_ok;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      epoch_r     <= EPOCH_FIRST;
      nb_r        <= '0;
      drain_r     <= '0;
      sweep_r     <= '0;
      conflict_r  <= 1'b0;
      clr_pend_r  <= 1'b0;
      rd_ok_r     <= 1'b0;
      out_valid_r <= 1'b0;
      cmd_r       <= CMD_CLEAR;
    end else begin
      state_r <= state_nxt;
      rd_ok_r <= (state_r == ST_SCAN) && nb_ok;
      if (hit) begin
        conflict_r <= 1'b1;
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_SWEEP: begin
          if (sweep_end) begin
            sweep_r    <= '0;
            epoch_r    <= EPOCH_FIRST;
            clr_pend_r <= 1'b0;
          end else begin
            sweep_r <= sweep_r + AW'(1);
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            cmd_r      <= in_chan.cmd;
            conflict_r <= 1'b0;
            nb_r       <= '0;
            drain_r    <= '0;
            if (in_chan.cmd == CMD_CLEAR) begin
              if (epoch_r == EPOCH_LAST) begin
                clr_pend_r <= 1'b1;
              end else begin
                epoch_r <= epoch_r + EPOCH_W'(1);
              end
            end
          end
        end
        ST_SCAN:  nb_r    <= nb_r + NB_W'(1);
        ST_DRAIN: drain_r <= drain_r + DRAIN_W'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_fire) begin
      px_r <= in_chan.point_x;
      py_r <= in_chan.point_y;
    end
    if (state_r == ST_DONE && out_free) begin
      out_res_r <= res;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.accepted    = out_res_r.accepted;
  assign out_chan.in_range    = out_res_r.in_range;
  assign out_chan.cell_column = out_res_r.cell_column;
  assign out_chan.cell_row    = out_res_r.cell_row;

endmodule

### verif/tb_poisson_disc_grid_checker.sv
`timescale 1ns / 100ps
// Self-checking bench for poisson_disc_grid_checker: directed and random candidates and
// clears over valid/ready channels, each result checked against an in-bench grid predictor.
// Depends on pdg_pkg, pdg_ifs and the poisson_disc_grid_checker RTL.
module tb_poisson_disc_grid_checker;
  import pdg_pkg::*;

  localparam int GRID = GRID_DIM_DEF;
  localparam int CW   = COORD_BITS_DEF;

  typedef struct {
    logic                 cmd;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
  } cand_t;

  logic clk = 1'b0;
  logic rst_n;

  pdg_in_if  in_if ();
  pdg_out_if out_if ();
  pdg_cfg_if cfg_if ();

  poisson_disc_grid_checker uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if),
    .cfg_chan(cfg_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [RSQ_W-1:0]  spacing_sq;
  logic [ICW_W-1:0]  inv_width;
  logic [GSZ_W-1:0]  grid_cells;
  logic [2*CW-1:0]   grid_pts [GRID*GRID];
  bit                grid_occ [GRID*GRID];

  cand_t pend_q[$];
  res_t  verdict_q[$];
  cand_t on_wire;
  int    idle_pct = 20;
  int    in_hold = 0;
  int    out_hold = 0;
  int    fails = 0;
  int    n_items = 0;
  int    n_checked = 0;
  int    n_stored = 0;
  int    n_outside = 0;
  int    n_clears = 0;

  function automatic res_t judge_candidate(cand_t c);
    res_t r;
    longint sx, sy, prod_x, prod_y, col, row, gs, nc, nr, ox, oy, dx, dy;
    longint unsigned dsq;
    int idx;
    bit far_enough;
    r = '0;
    if (c.cmd == CMD_CLEAR) begin
      foreach (grid_occ[i]) grid_occ[i] = 1'b0;
      return r;
    end
    gs = (grid_cells > GRID) ? GRID : grid_cells;
    sx = c.px;
    sy = c.py;
    prod_x = sx * longint'(inv_width);
    prod_y = sy * longint'(inv_width);
    if (prod_x < 0 || prod_y < 0) return r;
    col = prod_x >>> PROD_FRAC;
    row = prod_y >>> PROD_FRAC;
    if (col >= gs || row >= gs) return r;
    far_enough = 1'b1;
    for (int dc = -1; dc <= 1; dc++) begin
      for (int dr = -1; dr <= 1; dr++) begin
        nc = col + dc;
        nr = row + dr;
        if (nc < 0 || nr < 0 || nc >= gs || nr >= gs) continue;
        idx = int'(nc * GRID + nr);
        if (!grid_occ[idx]) continue;
        ox = signed'(grid_pts[idx][2*CW-1:CW]);
        oy = signed'(grid_pts[idx][CW-1:0]);
        dx = (sx >= ox) ? sx - ox : ox - sx;
        dy = (sy >= oy) ? sy - oy : oy - sy;
        dsq = dx * dx + dy * dy;
        if (dsq < spacing_sq) far_enough = 1'b0;
      end
    end
    if (far_enough) begin
      idx = int'(col * GRID + row);
      grid_pts[idx] = {c.px, c.py};
      grid_occ[idx] = 1'b1;
    end
    r.accepted    = far_enough;
    r.in_range    = 1'b1;
    r.cell_column = CELL_W'(col);
    r.cell_row    = CELL_W'(row);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        verdict_q = {verdict_q, judge_candidate(on_wire)};
        n_items++;
        if (on_wire.cmd == CMD_CLEAR) n_clears++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (in_hold > 0) begin
          in_hold--;
          in_if.valid <= 1'b0;
        end else if (pend_q.size() != 0) begin
          on_wire = pend_q.pop_front();
          in_if.valid   <= 1'b1;
          in_if.cmd     <= on_wire.cmd;
          in_if.point_x <= on_wire.px;
          in_if.point_y <= on_wire.py;
          if ($urandom_range(1, 100) <= idle_pct) in_hold = $urandom_range(1, 6);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (verdict_q.size() == 0) begin
          $error("result item with no expectation pending");
          fails++;
        end else begin
          want = verdict_q.pop_front();
          n_checked++;
          if (want.accepted) n_stored++;
          if (!want.in_range) n_outside++;
          if (out_if.accepted !== want.accepted) begin
            $error("accepted: expected %0b, got %0b", want.accepted, out_if.accepted);
            fails++;
          end
          if (out_if.in_range !== want.in_range) begin
            $error("in_range: expected %0b, got %0b", want.in_range, out_if.in_range);
            fails++;
          end
          if (out_if.cell_column !== want.cell_column) begin
            $error("cell_column: expected %0d, got %0d", want.cell_column, out_if.cell_column);
            fails++;
          end
          if (out_if.cell_row !== want.cell_row) begin
            $error("cell_row: expected %0d, got %0d", want.cell_row, out_if.cell_row);
            fails++;
          end
        end
      end
      if (out_hold > 0) begin
        out_hold--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if ($urandom_range(1, 100) <= idle_pct) out_hold = $urandom_range(1, 6);
      end
    end
  end

  task automatic wait_idle();
    do @(negedge clk); while (pend_q.size() != 0 || in_if.valid || verdict_q.size() != 0);
  endtask

  task automatic write_reg(cfg_reg_t which, logic [CFG_DATA_W-1:0] val);
    wait_idle();
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= which;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (which)
      REG_RADIUS_SQ: spacing_sq = val[RSQ_W-1:0];
      REG_INV_CELL:  inv_width  = val[ICW_W-1:0];
      REG_GRID_SIZE: grid_cells = val[GSZ_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_config(logic [RSQ_W-1:0] rsq, logic [ICW_W-1:0] icw,
                            logic [GSZ_W-1:0] gsz);
    write_reg(REG_RADIUS_SQ, CFG_DATA_W'(rsq));
    write_reg(REG_INV_CELL, CFG_DATA_W'(icw));
    write_reg(REG_GRID_SIZE, CFG_DATA_W'(gsz));
  endtask

  function automatic void add_item(logic cmd, int x, int y);
    cand_t c;
    c.cmd = cmd;
    c.px  = x[CW-1:0];
    c.py  = y[CW-1:0];
    pend_q = {pend_q, c};
  endfunction

  initial begin
    int pts_x[$];
    int pts_y[$];
    int s, gs, extent, span, pick, x, y;
    logic [RSQ_W-1:0] nom, rsq;
    logic [ICW_W-1:0] icw;

    in_if.valid   = 1'b0;
    in_if.cmd     = CMD_CLEAR;
    in_if.point_x = '0;
    in_if.point_y = '0;
    out_if.ready  = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = REG_RADIUS_SQ;
    cfg_if.data   = '0;
    spacing_sq    = '0;
    inv_width     = '0;
    grid_cells    = GRID_SIZE_RST;
    rst_n         = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: every point maps to cell 0 and nothing is too close
    add_item(CMD_TEST, 8388607, 8388607);
    add_item(CMD_TEST, -8388608, -8388608);
    add_item(CMD_CLEAR, 0, 0);

    // cell width of 256, radius squared of two squared cell widths, 8 by 8 grid
    set_config(48'd131072, 24'd65536, 7'd8);
    add_item(CMD_TEST, 0, 0);
    add_item(CMD_TEST, 128, 128);
    add_item(CMD_TEST, 512, 512);
    add_item(CMD_TEST, 384, 512);
    add_item(CMD_TEST, 2047, 2047);
    add_item(CMD_TEST, 2048, 0);
    add_item(CMD_TEST, -1, 256);
    add_item(CMD_TEST, 256, -256);
    add_item(CMD_CLEAR, -1, -1);
    add_item(CMD_TEST, 128, 128);
    add_item(CMD_TEST, 384, 384);
    add_item(CMD_TEST, 383, 384);

    set_config(48'hFFFF_FFFF_FFFF, 24'hFF_FFFF, 7'd1);
    add_item(CMD_CLEAR, 0, 0);
    add_item(CMD_TEST, 1, 1);
    add_item(CMD_TEST, 0, 0);
    add_item(CMD_TEST, 64, 64);

    // grid size beyond the array clamps to the full grid
    write_reg(REG_GRID_SIZE, CFG_DATA_W'(100));
    add_item(CMD_TEST, 64, 64);
    add_item(CMD_TEST, 65, 0);

    write_reg(REG_GRID_SIZE, CFG_DATA_W'(0));
    add_item(CMD_TEST, 0, 0);

    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      idle_pct = (ph == 7) ? 0 : $urandom_range(5, 35);
      s = $urandom_range(0, 5);
      icw = (s >= 2) ? (24'd65536 >> (s - 2)) : (24'd65536 << (2 - s));
      if (ph == 0) gs = GRID;
      else if (ph == 1) gs = 1;
      else gs = $urandom_range(2, GRID);
      nom = 48'd1 << (13 + 2 * s);
      case ($urandom_range(0, 9))
        0: rsq = '0;
        1: rsq = RSQ_W'({$urandom, $urandom});
        2: rsq = nom << 2;
        default: rsq = nom - $urandom_range(0, int'(nom >> 2));
      endcase
      set_config(rsq, icw, GSZ_W'(gs));
      extent = gs << (6 + s);
      span = 1 << (8 + s);
      pts_x.delete();
      pts_y.delete();
      add_item(CMD_CLEAR, $urandom, $urandom);
      for (int k = 0; k < 59; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          add_item(CMD_CLEAR, $urandom, $urandom);
        end else if (pick < 14) begin
          add_item(CMD_TEST, $urandom, $urandom);
        end else begin
          if (pick < 55 && pts_x.size() != 0) begin
            pick = $urandom_range(0, pts_x.size() - 1);
            x = pts_x[pick] + $urandom_range(0, 2 * span) - span;
            y = pts_y[pick] + $urandom_range(0, 2 * span) - span;
          end else begin
            x = $urandom_range(0, extent - 1);
            y = $urandom_range(0, extent - 1);
          end
          pts_x = {pts_x, x};
          pts_y = {pts_y, y};
          add_item(CMD_TEST, x, y);
        end
      end
    end

    wait_idle();
    repeat (40) @(posedge clk);
    $display("Checked %0d results for %0d items over 8 random settings plus directed cases.",
             n_checked, n_items);
    $display("%0d candidates stored, %0d rejected as outside the grid or cleared, %0d clears.",
             n_stored, n_outside, n_clears);
    if (fails == 0) begin
      $display("tb_poisson_disc_grid_checker passed");
    end else begin
      $display("tb_poisson_disc_grid_checker failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_poisson_disc_grid_checker failed");
    $finish;
  end

endmodule

### filelist.f
rtl/pdg_pkg.sv
rtl/pdg_ifs.sv
rtl/pdg_grid_mem.sv
rtl/pdg_cell_map.sv
rtl/pdg_dist.sv
rtl/poisson_disc_grid_checker.sv
verif/tb_poisson_disc_grid_checker.sv
